>>> rtl/clhb_pkg.sv
// ---------------------------------------------------------------------------
// clhb_pkg
// Shared codes, configuration layout and sizing helpers for the console
// line history buffer.
// ---------------------------------------------------------------------------
package clhb_pkg;

    // Word function codes
    localparam logic [2:0] FUNC_CHAR      = 3'd0;
    localparam logic [2:0] FUNC_END_WRITE = 3'd1;
    localparam logic [2:0] FUNC_RULER     = 3'd2;
    localparam logic [2:0] FUNC_FLUSH     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;
    localparam logic [2:0] FUNC_READ      = 3'd5;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] RULER_MARK   = 8'h80;

    // Register map: word index taken from paddr[3:2]
    localparam int         PADDR_W            = 4;
    localparam logic [1:0] REG_MAX_LINE_LEN   = 2'd0;
    localparam logic [1:0] REG_MAX_LINES      = 2'd1;
    localparam logic [1:0] REG_ALWAYS_FLUSH   = 2'd2;

    localparam logic [7:0] MAX_LINE_LEN_RESET = 8'd128;
    localparam logic [5:0] MAX_LINES_RESET    = 6'd32;

    typedef struct packed {
        logic [7:0] max_line_len;
        logic [5:0] max_lines;
        logic       always_flush;
    } cfg_t;

    // Physical ring size: one spare slot so the line being assembled never
    // overlaps a held line, rounded up to even so two consecutive slots
    // always fall in different metadata banks.
    function automatic int ring_slots(input int lines);
        return ((lines + 2) / 2) * 2;
    endfunction

endpackage

>>> rtl/clhb_regs.sv
// ---------------------------------------------------------------------------
// clhb_regs
// APB configuration registers: line length, history depth, always-flush.
// ---------------------------------------------------------------------------
module clhb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clhb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output clhb_pkg::cfg_t                cfg
);

    clhb_pkg::cfg_t cfg_reg;
    clhb_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                clhb_pkg::REG_MAX_LINE_LEN: cfg_next.max_line_len = pwdata[7:0];
                clhb_pkg::REG_MAX_LINES:    cfg_next.max_lines    = pwdata[5:0];
                clhb_pkg::REG_ALWAYS_FLUSH: cfg_next.always_flush = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            clhb_pkg::REG_MAX_LINE_LEN: prdata = {24'd0, cfg_reg.max_line_len};
            clhb_pkg::REG_MAX_LINES:    prdata = {26'd0, cfg_reg.max_lines};
            clhb_pkg::REG_ALWAYS_FLUSH: prdata = {31'd0, cfg_reg.always_flush};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_line_len <= clhb_pkg::MAX_LINE_LEN_RESET;
            cfg_reg.max_lines    <= clhb_pkg::MAX_LINES_RESET;
            cfg_reg.always_flush <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/clhb_ctrl.sv
// ---------------------------------------------------------------------------
// clhb_ctrl
// Line bookkeeping: pending count and flags, ring pointers, write commands
// for the text and metadata stores, and read slot lookup.
// ---------------------------------------------------------------------------
module clhb_ctrl #(
    parameter int MAX_LINES      = 32,
    parameter int MAX_LINE_CHARS = 128,
    localparam int SLOTS     = clhb_pkg::ring_slots(MAX_LINES),
    localparam int SW        = $clog2(SLOTS),
    localparam int BW        = SW - 1,
    localparam int CPW       = $clog2(MAX_LINE_CHARS),
    localparam int LCW       = $clog2(MAX_LINES + 1),
    localparam int EW        = (LCW > 6) ? LCW : 6,
    localparam int IW        = (LCW > 7) ? LCW : 7,
    localparam int LEN_CAP   = (MAX_LINE_CHARS > 255) ? 255 : MAX_LINE_CHARS,
    localparam int LINES_CAP = (MAX_LINES > 63) ? 63 : MAX_LINES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  clhb_pkg::cfg_t          cfg,
    input  logic                    go,
    input  logic [2:0]              func,
    input  logic [7:0]              char_code,
    input  logic [7:0]              line_flags,
    input  logic signed [6:0]       line_index,
    output logic                    txt_we,
    output logic [SW+CPW-1:0]       txt_waddr,
    output logic [7:0]              txt_wdata,
    output logic [1:0]              meta_we,
    output logic [1:0][BW-1:0]      meta_waddr,
    output logic [1:0][15:0]        meta_wdata,
    output logic [SW-1:0]           rd_slot,
    output logic                    rd_hit,
    output logic [5:0]              lines_held
);

    logic [LCW-1:0] count_reg, count_next;
    logic [SW-1:0]  oldest_reg, oldest_next;
    logic [SW-1:0]  pend_reg, pend_next;
    logic [7:0]     pcnt_reg, pcnt_next;
    logic [7:0]     pflags_reg, pflags_next;

    logic [7:0]     eff_len;
    logic [5:0]     eff_lines;
    logic [7:0]     pcnt_sat;
    logic [7:0]     pcnt_base;
    logic [7:0]     close_flags;
    logic           is_char, is_end, is_ruler, is_flush, is_clear, is_nl;
    logic           want_close, close_a, grow_a, grow_b;
    logic [LCW-1:0] count_a, count_b;
    logic [SW-1:0]  oldest_a, oldest_b, pend_a, pend_b;
    logic           a_hit, b_hit;

    logic [6:0]     back;
    logic [IW-1:0]  cnt_i, back_i, idx;
    logic [SW:0]    slot_sum;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(SLOTS - 1)) ? '0 : s + SW'(1);
    endfunction

    always_comb
    begin
        if (cfg.max_line_len == 8'd0)
            eff_len = 8'd1;
        else if (cfg.max_line_len > 8'(LEN_CAP))
            eff_len = 8'(LEN_CAP);
        else
            eff_len = cfg.max_line_len;

        if (cfg.max_lines == 6'd0)
            eff_lines = 6'd1;
        else if (cfg.max_lines > 6'(LINES_CAP))
            eff_lines = 6'(LINES_CAP);
        else
            eff_lines = cfg.max_lines;

        // A shorter line length takes effect on the pending count at once.
        pcnt_sat = (pcnt_reg > eff_len) ? eff_len : pcnt_reg;

        is_char  = go && (func == clhb_pkg::FUNC_CHAR);
        is_end   = go && (func == clhb_pkg::FUNC_END_WRITE);
        is_ruler = go && (func == clhb_pkg::FUNC_RULER);
        is_flush = go && (func == clhb_pkg::FUNC_FLUSH);
        is_clear = go && (func == clhb_pkg::FUNC_CLEAR);
        is_nl    = (char_code == clhb_pkg::NEWLINE_CODE);

        want_close = (is_char && (is_nl || (pcnt_sat >= eff_len))) || is_ruler || is_flush
                     || (is_end && cfg.always_flush);
        close_a     = want_close && (pcnt_sat != 8'd0);
        close_flags = is_char ? line_flags : pflags_reg;

        // First append: the pending line. Second append: the ruler line.
        grow_a   = EW'(count_reg) < EW'(eff_lines);
        count_a  = (close_a && grow_a) ? count_reg + LCW'(1) : count_reg;
        oldest_a = (close_a && !grow_a) ? slot_inc(oldest_reg) : oldest_reg;
        pend_a   = close_a ? slot_inc(pend_reg) : pend_reg;

        grow_b   = EW'(count_a) < EW'(eff_lines);
        count_b  = (is_ruler && grow_b) ? count_a + LCW'(1) : count_a;
        oldest_b = (is_ruler && !grow_b) ? slot_inc(oldest_a) : oldest_a;
        pend_b   = is_ruler ? slot_inc(pend_a) : pend_a;

        if (is_clear)
        begin
            count_next  = '0;
            oldest_next = '0;
            pend_next   = '0;
        end
        else
        begin
            count_next  = count_b;
            oldest_next = oldest_b;
            pend_next   = pend_b;
        end

        pcnt_base = close_a ? 8'd0 : pcnt_sat;
        if (is_char)
            pcnt_next = is_nl ? 8'd0 : pcnt_base + 8'd1;
        else if (is_clear)
            pcnt_next = 8'd0;
        else
            pcnt_next = pcnt_base;

        if (close_a)
            pflags_next = 8'd0;
        else if (is_char)
            pflags_next = line_flags;
        else
            pflags_next = pflags_reg;

        // Characters go straight into the slot of the line being assembled.
        txt_we    = is_char && !is_nl;
        txt_waddr = {pend_a, CPW'(pcnt_base)};
        txt_wdata = char_code;

        // Consecutive slots have opposite parity, so each bank sees at most one write.
        for (int k = 0; k < 2; k++)
        begin
            a_hit = close_a && (pend_reg[0] == k[0]);
            b_hit = is_ruler && (pend_a[0] == k[0]);
            meta_we[k]    = a_hit || b_hit;
            meta_waddr[k] = b_hit ? pend_a[SW-1:1] : pend_reg[SW-1:1];
            meta_wdata[k] = b_hit ? {8'd0, clhb_pkg::RULER_MARK} : {pcnt_sat, close_flags};
        end

        // Read lookup; a negative index counts back and clamps to the oldest.
        back   = ~line_index + 7'd1;
        cnt_i  = IW'(count_reg);
        back_i = IW'(back);
        if (line_index[6])
            idx = (back_i > cnt_i) ? '0 : cnt_i - back_i;
        else
            idx = IW'(line_index[5:0]);
        rd_hit   = idx < cnt_i;
        slot_sum = (SW + 1)'(oldest_reg) + (SW + 1)'(idx);
        if (slot_sum >= (SW + 1)'(SLOTS))
            rd_slot = SW'(slot_sum - (SW + 1)'(SLOTS));
        else
            rd_slot = SW'(slot_sum);

        lines_held = 6'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            oldest_reg <= '0;
            pend_reg   <= '0;
            pcnt_reg   <= 8'd0;
            pflags_reg <= 8'd0;
        end
        else
        begin
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            pend_reg   <= pend_next;
            pcnt_reg   <= pcnt_next;
            pflags_reg <= pflags_next;
        end
    end

endmodule

>>> rtl/clhb_store.sv
// ---------------------------------------------------------------------------
// clhb_store
// Text memory and two banks of line metadata, with registered read data and
// gating of fields for lines that are not held.
// ---------------------------------------------------------------------------
module clhb_store #(
    parameter int MAX_LINES      = 32,
    parameter int MAX_LINE_CHARS = 128,
    localparam int SLOTS      = clhb_pkg::ring_slots(MAX_LINES),
    localparam int SW         = $clog2(SLOTS),
    localparam int BW         = SW - 1,
    localparam int CPW        = $clog2(MAX_LINE_CHARS),
    localparam int TEXT_DEPTH = SLOTS * (2 ** CPW),
    localparam int BANK_DEPTH = SLOTS / 2
) (
    input  logic                    clk,
    input  logic                    txt_we,
    input  logic [SW+CPW-1:0]       txt_waddr,
    input  logic [7:0]              txt_wdata,
    input  logic [1:0]              meta_we,
    input  logic [1:0][BW-1:0]      meta_waddr,
    input  logic [1:0][15:0]        meta_wdata,
    input  logic                    rd_load,
    input  logic [SW-1:0]           rd_slot,
    input  logic [6:0]              rd_pos,
    input  logic                    rd_hit,
    input  logic [5:0]              rd_lines,
    output logic [7:0]              text_byte,
    output logic [7:0]              text_length,
    output logic [7:0]              flags_read,
    output logic                    line_valid,
    output logic [5:0]              lines_held
);

    logic [7:0]  text_mem [TEXT_DEPTH];
    logic [15:0] meta_even [BANK_DEPTH];
    logic [15:0] meta_odd  [BANK_DEPTH];

    logic [7:0]  text_q_reg;
    logic [15:0] even_q_reg, odd_q_reg;
    logic        odd_sel_reg;
    logic        hit_reg;
    logic [6:0]  pos_reg;
    logic [5:0]  lines_reg;
    logic [15:0] meta_sel;

    always_ff @(posedge clk)
    begin
        if (txt_we)
            text_mem[txt_waddr] <= txt_wdata;
        if (rd_load)
            text_q_reg <= text_mem[{rd_slot, CPW'(rd_pos)}];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we[0])
            meta_even[meta_waddr[0]] <= meta_wdata[0];
        if (rd_load)
            even_q_reg <= meta_even[rd_slot[SW-1:1]];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we[1])
            meta_odd[meta_waddr[1]] <= meta_wdata[1];
        if (rd_load)
            odd_q_reg <= meta_odd[rd_slot[SW-1:1]];
    end

    always_ff @(posedge clk)
    begin
        if (rd_load)
        begin
            odd_sel_reg <= rd_slot[0];
            hit_reg     <= rd_hit;
            pos_reg     <= rd_pos;
            lines_reg   <= rd_lines;
        end
    end

    always_comb
    begin
        meta_sel    = odd_sel_reg ? odd_q_reg : even_q_reg;
        line_valid  = hit_reg;
        text_length = hit_reg ? meta_sel[15:8] : 8'd0;
        flags_read  = hit_reg ? meta_sel[7:0] : 8'd0;
        // Bytes at or past the line end read as zero.
        text_byte   = (hit_reg && ({1'b0, pos_reg} < meta_sel[15:8])) ? text_q_reg : 8'd0;
        lines_held  = lines_reg;
    end

endmodule

>>> rtl/console_line_history_buffer.sv
// ---------------------------------------------------------------------------
// console_line_history_buffer
// Assembles text bytes into lines and keeps the newest lines in a ring.
//
// Input words (in_valid / in_stall) carry a function code and its operands:
// character, end of write, ruler, flush, clear or read. Only a read word
// produces an output word (out_valid / out_stall) with the byte, length and
// flags of the addressed line and the current number of held lines.
// A word is held in the input register, where all bookkeeping is done and
// the memories are written or read; a read result is then loaded into the
// output register. One word is accepted every cycle while in_stall is low;
// the rate is set by the single write port and single read port of the text
// memory. While out_stall holds a result, non-read words keep flowing; a
// read word waits in the input register and in_stall rises behind it.
// Reset empties the history and the pending line and loads the register
// defaults (128 bytes per line, 32 lines, always-flush off). The stores
// need no clearing pass, so a word can be accepted right after reset.
// The user writes configuration over the APB port while idle; not enforced.
// ---------------------------------------------------------------------------
module console_line_history_buffer #(
    parameter int MAX_LINES      = 32,
    parameter int MAX_LINE_CHARS = 128,
    localparam int SLOTS = clhb_pkg::ring_slots(MAX_LINES),
    localparam int SW    = $clog2(SLOTS),
    localparam int BW    = SW - 1,
    localparam int CPW   = $clog2(MAX_LINE_CHARS)
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clhb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    func,
    input  logic [7:0]                    char_code,
    input  logic [7:0]                    line_flags,
    input  logic signed [6:0]             line_index,
    input  logic [6:0]                    char_position,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    text_byte,
    output logic [7:0]                    text_length,
    output logic [7:0]                    flags_read,
    output logic                          line_valid,
    output logic [5:0]                    lines_held
);

    clhb_pkg::cfg_t cfg;

    logic              s1_valid_reg, s1_valid_next;
    logic [2:0]        s1_func_reg;
    logic [7:0]        s1_char_reg;
    logic [7:0]        s1_flags_reg;
    logic signed [6:0] s1_index_reg;
    logic [6:0]        s1_pos_reg;
    logic              out_valid_reg, out_valid_next;

    logic              s1_is_read;
    logic              s2_free;
    logic              s1_go;
    logic              accept;
    logic              rd_load;

    logic                  txt_we;
    logic [SW+CPW-1:0]     txt_waddr;
    logic [7:0]            txt_wdata;
    logic [1:0]            meta_we;
    logic [1:0][BW-1:0]    meta_waddr;
    logic [1:0][15:0]      meta_wdata;
    logic [SW-1:0]         rd_slot;
    logic                  rd_hit;
    logic [5:0]            rd_lines;

    assign s1_is_read = (s1_func_reg == clhb_pkg::FUNC_READ);
    assign s2_free    = !out_valid_reg || !out_stall;
    assign s1_go      = s1_valid_reg && (!s1_is_read || s2_free);
    assign in_stall   = s1_valid_reg && !s1_go;
    assign accept     = in_valid && !in_stall;
    assign rd_load    = s1_go && s1_is_read;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (rd_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= func;
            s1_char_reg  <= char_code;
            s1_flags_reg <= line_flags;
            s1_index_reg <= line_index;
            s1_pos_reg   <= char_position;
        end
    end

    clhb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clhb_ctrl #(
        .MAX_LINES      (MAX_LINES),
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .go         (s1_go),
        .func       (s1_func_reg),
        .char_code  (s1_char_reg),
        .line_flags (s1_flags_reg),
        .line_index (s1_index_reg),
        .txt_we     (txt_we),
        .txt_waddr  (txt_waddr),
        .txt_wdata  (txt_wdata),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .rd_slot    (rd_slot),
        .rd_hit     (rd_hit),
        .lines_held (rd_lines)
    );

    clhb_store #(
        .MAX_LINES      (MAX_LINES),
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_store (
        .clk         (clk),
        .txt_we      (txt_we),
        .txt_waddr   (txt_waddr),
        .txt_wdata   (txt_wdata),
        .meta_we     (meta_we),
        .meta_waddr  (meta_waddr),
        .meta_wdata  (meta_wdata),
        .rd_load     (rd_load),
        .rd_slot     (rd_slot),
        .rd_pos      (s1_pos_reg),
        .rd_hit      (rd_hit),
        .rd_lines    (rd_lines),
        .text_byte   (text_byte),
        .text_length (text_length),
        .flags_read  (flags_read),
        .line_valid  (line_valid),
        .lines_held  (lines_held)
    );

endmodule
